// ===== rtl/phn_pkg.sv =====
// Shared types and constants of the pixel histogram normalizer.
`default_nettype none

package phn_pkg;

    localparam int BIN_W      = 8;
    localparam int NUM_BINS   = 256;
    localparam int FUNC_W     = 2;
    localparam int HEIGHT_W   = 8;
    localparam int QUOT_W     = 8;
    localparam int MUL_W      = 8;

    localparam logic [HEIGHT_W-1:0] FULL_HEIGHT_RST = 8'd230;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [BIN_W-1:0] rd_addr;
        logic             wr_en;
        logic [BIN_W-1:0] wr_addr;
        logic             clr;
    } ram_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pixel_histogram_normalizer_core.sv =====
// Top level: 256-bin pixel histogram with peak-normalized bin readback.
// Add pixel: bin RAM read, then write-back and peak update.
// Read bin: bin RAM read, then load of the count and divider start, then the
//   8-step serial divider; the result is loaded once the output is free. An
//   empty histogram skips the divider. Clear and unused codes leave the block idle. Reset: async,
//   active low; clears valid bits, peak and control state, full_height to 230.
`default_nettype none

module pixel_histogram_normalizer_core #(
    parameter  int MAX_PIXELS = 65536,
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [phn_pkg::FUNC_W-1:0]     func,
    input  wire logic [phn_pkg::BIN_W-1:0]      intensity,
    input  wire logic [phn_pkg::BIN_W-1:0]      bin_index,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [CNT_W-1:0]               bin_count,
    output logic      [phn_pkg::HEIGHT_W-1:0]   bin_height,
    // configuration channel (full_height)
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [phn_pkg::HEIGHT_W-1:0]   cfg_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    phn_pkg::state_t     state_reg;
    phn_pkg::state_t     state_next;
    phn_pkg::func_t      cmd;
    phn_pkg::ram_ctrl_t  ram_ctrl;

    logic [CNT_W-1:0]               peak_reg;
    logic [CNT_W-1:0]               peak_next;
    logic [phn_pkg::HEIGHT_W-1:0]   fh_reg;
    logic [phn_pkg::BIN_W-1:0]      addr_reg;
    logic [phn_pkg::BIN_W-1:0]      addr_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [phn_pkg::HEIGHT_W-1:0]   height_reg;
    logic [phn_pkg::HEIGHT_W-1:0]   height_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [CNT_W-1:0]               bin_count_reg;
    logic [CNT_W-1:0]               bin_count_next;
    logic [phn_pkg::HEIGHT_W-1:0]   bin_height_reg;
    logic [phn_pkg::HEIGHT_W-1:0]   bin_height_next;

    logic [CNT_W-1:0]               rd_data;
    logic [CNT_W-1:0]               cnt_new;
    logic                           below_max;
    logic                           out_free;
    logic                           div_start;
    logic                           div_done;
    logic [phn_pkg::QUOT_W-1:0]     div_quot;

    assign cmd       = phn_pkg::func_t'(func);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Saturating increment of the bin read back from RAM.
    assign below_max = (rd_data < MAX_CNT);
    assign cnt_new   = below_max ? (rd_data + 1'b1) : rd_data;

    phn_bin_ram #(
        .DATA_W (CNT_W)
    ) u_bin_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ram_ctrl),
        .wr_data (cnt_new),
        .rd_data (rd_data)
    );

    phn_divider #(
        .NUM_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mul_a    (rd_data),
        .mul_b    (fh_reg),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state. Only one command is in flight, which interlocks the
    // read-modify-write of a bin against the next command.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            phn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        phn_pkg::FUNC_ADD:  state_next = phn_pkg::ST_MODIFY;
                        phn_pkg::FUNC_READ: state_next = phn_pkg::ST_LOAD;
                        default:            state_next = phn_pkg::ST_IDLE;
                    endcase
                end
            end
            phn_pkg::ST_MODIFY:
            begin
                state_next = phn_pkg::ST_IDLE;
            end
            phn_pkg::ST_LOAD:
            begin
                // An empty histogram skips the divider: height is zero.
                state_next = (peak_reg != '0) ? phn_pkg::ST_DIVIDE : phn_pkg::ST_DONE;
            end
            phn_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = phn_pkg::ST_DONE;
                end
            end
            phn_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = phn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = phn_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs: input stall, RAM strobes, divider start.
    always_comb
    begin
        in_stall          = 1'b1;
        ram_ctrl          = '0;
        ram_ctrl.wr_addr  = addr_reg;
        div_start         = 1'b0;
        case (state_reg)
            phn_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (cmd)
                        phn_pkg::FUNC_ADD:
                        begin
                            ram_ctrl.rd_en   = 1'b1;
                            ram_ctrl.rd_addr = intensity;
                        end
                        phn_pkg::FUNC_READ:
                        begin
                            ram_ctrl.rd_en   = 1'b1;
                            ram_ctrl.rd_addr = bin_index;
                        end
                        phn_pkg::FUNC_CLEAR:
                        begin
                            ram_ctrl.clr = 1'b1;
                        end
                        default:
                        begin
                            ram_ctrl.clr = 1'b0;
                        end
                    endcase
                end
            end
            phn_pkg::ST_MODIFY:
            begin
                // Skip the write for a saturated bin.
                ram_ctrl.wr_en = below_max;
            end
            phn_pkg::ST_LOAD:
            begin
                div_start = (peak_reg != '0);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        peak_next       = peak_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        height_next     = height_reg;
        out_valid_next  = out_valid_reg;
        bin_count_next  = bin_count_reg;
        bin_height_next = bin_height_reg;

        // Drop the result once the transfer completes.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            phn_pkg::ST_IDLE:
            begin
                addr_next = intensity;
                if (in_valid && (cmd == phn_pkg::FUNC_CLEAR))
                begin
                    peak_next = '0;
                end
            end
            phn_pkg::ST_MODIFY:
            begin
                if (cnt_new > peak_reg)
                begin
                    peak_next = cnt_new;
                end
            end
            phn_pkg::ST_LOAD:
            begin
                count_next  = rd_data;
                height_next = '0;
            end
            phn_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    height_next = div_quot;
                end
            end
            phn_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    bin_count_next  = count_reg;
                    bin_height_next = height_reg;
                end
            end
            default:
            begin
                peak_next = peak_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phn_pkg::ST_IDLE;
            peak_reg      <= '0;
            fh_reg        <= phn_pkg::FULL_HEIGHT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                fh_reg <= cfg_data;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        count_reg      <= count_next;
        height_reg     <= height_next;
        bin_count_reg  <= bin_count_next;
        bin_height_reg <= bin_height_next;
    end

    assign out_valid  = out_valid_reg;
    assign bin_count  = bin_count_reg;
    assign bin_height = bin_height_reg;

    // A written bin never passes the capacity.
    a_wr_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctrl.wr_en |-> (cnt_new <= MAX_CNT))
        else $error("bin write above capacity");

    // The peak covers every count written back.
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctrl.wr_en |=> (peak_reg >= $past(cnt_new)))
        else $error("peak below a written bin count");

    // The divider never starts on a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (peak_reg != '0))
        else $error("divider started with zero peak");

    // A new result comes only out of the result-ready state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall)) |->
            (state_reg == phn_pkg::ST_DONE))
        else $error("result loaded outside the done state");

endmodule

`default_nettype wire

// ===== rtl/phn_bin_ram.sv =====
// Bin count memory with registered read and per-entry valid bits.
`default_nettype none

module phn_bin_ram #(
    parameter int DATA_W = 17
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire phn_pkg::ram_ctrl_t ctrl,
    input  wire logic [DATA_W-1:0]  wr_data,
    output logic      [DATA_W-1:0]  rd_data
);

    logic [DATA_W-1:0]            mem_reg [phn_pkg::NUM_BINS];
    logic [phn_pkg::NUM_BINS-1:0] valid_reg;
    logic [DATA_W-1:0]            rd_data_reg;
    logic                         rd_valid_reg;

    // Write port; no reset on the array itself.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_reg[ctrl.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem_reg[ctrl.rd_addr];
        end
    end

    // Clear drops every valid bit at once; an invalid entry reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/phn_divider.sv =====
// Multiply then restoring divide, one quotient bit per cycle.
`default_nettype none

module phn_divider #(
    parameter int NUM_W = 17
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [NUM_W-1:0]             mul_a,
    input  wire logic [phn_pkg::MUL_W-1:0]    mul_b,
    input  wire logic [NUM_W-1:0]             divisor,
    output logic                              done,
    output logic      [phn_pkg::QUOT_W-1:0]   quotient
);

    localparam int PROD_W = NUM_W + phn_pkg::MUL_W;
    localparam int STEP_W = $clog2(phn_pkg::QUOT_W + 1);

    logic [PROD_W-1:0]          prod;
    logic [NUM_W-1:0]           rem_reg;
    logic [NUM_W-1:0]           rem_next;
    logic [phn_pkg::QUOT_W-1:0] low_reg;
    logic [NUM_W-1:0]           dvs_reg;
    logic [phn_pkg::QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [NUM_W:0]             trial;
    logic                       q_bit;

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Quotient fits in QUOT_W bits, so the high product part starts below the divisor.
    always_comb
    begin
        trial = {rem_reg, low_reg[phn_pkg::QUOT_W-1]};
        q_bit = (trial >= {1'b0, dvs_reg});
        if (q_bit)
        begin
            rem_next = NUM_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[NUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= prod[PROD_W-1:phn_pkg::QUOT_W];
            low_reg  <= prod[phn_pkg::QUOT_W-1:0];
            dvs_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[phn_pkg::QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[phn_pkg::QUOT_W-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(phn_pkg::QUOT_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== verif/pixel_histogram_normalizer_core_tb.sv =====
// Self-checking testbench for the pixel histogram normalizer core.
`timescale 1ns / 100ps

module pixel_histogram_normalizer_core_tb;

    localparam int CNT_W       = 17;
    localparam int SAT_LIMIT   = 65536;
    localparam int HOLD_CYCLES = 400;
    localparam int TALL_COUNT  = 200;
    // A read holds the block until its result is loaded; give adds and clears that trail
    // the last read enough room to retire before touching full_height.
    localparam int SETTLE      = 16;
    localparam logic [phn_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [phn_pkg::FUNC_W-1:0] func;
        logic [phn_pkg::BIN_W-1:0]  intensity;
        logic [phn_pkg::BIN_W-1:0]  bin_index;
    } pixel_cmd_t;

    typedef struct {
        logic [CNT_W-1:0]             count;
        logic [phn_pkg::HEIGHT_W-1:0] height;
    } bin_readout_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [phn_pkg::FUNC_W-1:0]      func = '0;
    logic [phn_pkg::BIN_W-1:0]       intensity = '0;
    logic [phn_pkg::BIN_W-1:0]       bin_index = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [CNT_W-1:0]                bin_count;
    logic [phn_pkg::HEIGHT_W-1:0]    bin_height;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [phn_pkg::HEIGHT_W-1:0]    cfg_data = '0;

    // Shadow copy of the histogram, its peak and the height setting.
    logic [CNT_W-1:0]                hist_bins [phn_pkg::NUM_BINS];
    logic [CNT_W-1:0]                hist_peak;
    logic [phn_pkg::HEIGHT_W-1:0]    hist_full_height;

    pixel_cmd_t                      cmd_queue[$];
    bin_readout_t                    pending_reads[$];
    idle_mode_t                      idle_mode = IDLE_NONE;
    logic                            hold_start = 1'b0;
    int                              hold_left;
    int                              err_count = 0;
    logic [phn_pkg::BIN_W-1:0]       hot_bins [4];

    pixel_histogram_normalizer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .intensity  (intensity),
        .bin_index  (bin_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bin_count  (bin_count),
        .bin_height (bin_height),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Advance the shadow histogram by one accepted command; a read pushes
    // the count and the normalized height it must return.
    function automatic void apply_command(input pixel_cmd_t cmd);
        logic [CNT_W-1:0] cnt;
        bin_readout_t     res;
        case (cmd.func)
            phn_pkg::FUNC_ADD:
            begin
                cnt = hist_bins[cmd.intensity];
                // Saturated bin: hold at the pixel capacity.
                if (cnt < SAT_LIMIT)
                begin
                    cnt = cnt + 1'b1;
                    hist_bins[cmd.intensity] = cnt;
                end
                if (cnt > hist_peak)
                    hist_peak = cnt;
            end
            phn_pkg::FUNC_READ:
            begin
                res.count = hist_bins[cmd.bin_index];
                // Empty histogram gives height 0; otherwise floor the exact
                // quotient. The product fits easily in 32 bits.
                if (hist_peak == '0)
                    res.height = '0;
                else
                    res.height = 8'(32'(res.count) * 32'(hist_full_height)
                                    / 32'(hist_peak));
                pending_reads.push_back(res);
            end
            phn_pkg::FUNC_CLEAR:
            begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                hist_peak = '0;
            end
            default: ;  // unused selector: no effect, no result
        endcase
    endfunction

    function automatic logic roll_idle(input idle_mode_t mine);
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 11;
        if (idle_mode == mine)
            return $urandom_range(99) < 72;
        return 1'b0;
    endfunction

    // Driver: present the next queued command once the current one has
    // transferred; hold the payload while the block stalls.
    always @(posedge clk)
    begin : cmd_driver
        pixel_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                nxt.func      = func;
                nxt.intensity = intensity;
                nxt.bin_index = bin_index;
                apply_command(nxt);
            end
            if (!in_valid || !in_stall)
            begin
                if (cmd_queue.size() != 0 && !roll_idle(IDLE_SENDER))
                begin
                    nxt = cmd_queue.pop_front();
                    in_valid  <= 1'b1;
                    func      <= nxt.func;
                    intensity <= nxt.intensity;
                    bin_index <= nxt.bin_index;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only reads it.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: check every result transfer against the oldest pending read.
    always @(posedge clk)
    begin : result_monitor
        bin_readout_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reads.size() == 0)
                begin
                    report_mismatch($sformatf("result with no read pending: count %0d height %0d",
                                              bin_count, bin_height));
                end
                else
                begin
                    want = pending_reads.pop_front();
                    if (bin_count !== want.count)
                        report_mismatch($sformatf("bin_count got %0d want %0d",
                                                  bin_count, want.count));
                    if (bin_height !== want.height)
                        report_mismatch($sformatf("bin_height got %0d want %0d",
                                                  bin_height, want.height));
                end
            end
            out_stall <= (hold_left != 0) || roll_idle(IDLE_RECEIVER);
        end
    end

    task automatic push_cmd(input logic [phn_pkg::FUNC_W-1:0] f,
                            input logic [phn_pkg::BIN_W-1:0] pix,
                            input logic [phn_pkg::BIN_W-1:0] sel);
        pixel_cmd_t cmd;
        cmd.func      = f;
        cmd.intensity = pix;
        cmd.bin_index = sel;
        cmd_queue.push_back(cmd);
    endtask

    // Mostly adds and reads around a few hot bins so tall peaks build up;
    // clears are rare so the histogram grows between them. Unused codes do
    // not count toward n.
    task automatic queue_random(input int n);
        int                        done;
        int                        r;
        logic [phn_pkg::BIN_W-1:0] pix;
        logic [phn_pkg::BIN_W-1:0] sel;
        done = 0;
        while (done < n)
        begin
            r   = $urandom_range(99);
            pix = $urandom_range(1) ? hot_bins[$urandom_range(3)] : 8'($urandom_range(255));
            sel = $urandom_range(1) ? hot_bins[$urandom_range(3)] : 8'($urandom_range(255));
            if (r < 55)
                push_cmd(phn_pkg::FUNC_ADD, pix, sel);
            else if (r < 91)
                push_cmd(phn_pkg::FUNC_READ, pix, sel);
            else if (r < 93)
                push_cmd(phn_pkg::FUNC_CLEAR, pix, sel);
            else
                push_cmd(FUNC_UNUSED, pix, sel);
            if (r < 93)
                done++;
        end
    endtask

    task automatic pick_hot_bins();
        foreach (hot_bins[i])
            hot_bins[i] = 8'($urandom_range(255));
    endtask

    // Wait at falling edges, where every transfer of the step has settled,
    // until all commands are in and all reads answered; then let trailing
    // adds and clears retire.
    task automatic wait_idle();
        int guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while ((cmd_queue.size() != 0 || in_valid || pending_reads.size() != 0)
               && guard < 400000);
        while (pending_reads.size() != 0)
        begin
            report_mismatch($sformatf("read never answered: count %0d height %0d",
                                      pending_reads[0].count, pending_reads[0].height));
            void'(pending_reads.pop_front());
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_full_height(input logic [phn_pkg::HEIGHT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        hist_full_height = value;
    endtask

    initial
    begin
        foreach (hist_bins[i])
            hist_bins[i] = '0;
        hist_peak        = '0;
        hist_full_height = phn_pkg::FULL_HEIGHT_RST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty reads, unused code, extreme bins, clear, reread.
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd0);
        push_cmd(FUNC_UNUSED, 8'd0, 8'd0);
        push_cmd(phn_pkg::FUNC_ADD, 8'd0, 8'd0);
        push_cmd(phn_pkg::FUNC_ADD, 8'd255, 8'd0);
        push_cmd(phn_pkg::FUNC_ADD, 8'd255, 8'd255);
        push_cmd(phn_pkg::FUNC_ADD, 8'd170, 8'd85);
        push_cmd(phn_pkg::FUNC_ADD, 8'd85, 8'd170);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd255);
        push_cmd(phn_pkg::FUNC_READ, 8'd255, 8'd0);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd170);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd85);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd7);
        push_cmd(phn_pkg::FUNC_CLEAR, 8'd255, 8'd255);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd255);
        push_cmd(FUNC_UNUSED, 8'd255, 8'd255);
        push_cmd(phn_pkg::FUNC_ADD, 8'd255, 8'd0);
        push_cmd(phn_pkg::FUNC_READ, 8'd0, 8'd255);
        wait_idle();

        // Tall bin: pile pixels into one bin at the widest height, then
        // read it back at full scale and a small bin at a low height.
        write_full_height(8'd255);
        push_cmd(phn_pkg::FUNC_CLEAR, 8'd0, 8'd0);
        repeat (TALL_COUNT)
            push_cmd(phn_pkg::FUNC_ADD, 8'h3C, 8'h00);
        repeat (3)
            push_cmd(phn_pkg::FUNC_ADD, 8'hC3, 8'h00);
        push_cmd(phn_pkg::FUNC_READ, 8'h00, 8'h3C);
        push_cmd(phn_pkg::FUNC_READ, 8'h00, 8'hC3);
        wait_idle();

        // Random phases, one per idle pattern and height setting.
        write_full_height(8'd1);
        idle_mode = IDLE_SENDER;
        pick_hot_bins();
        push_cmd(phn_pkg::FUNC_CLEAR, 8'd0, 8'd0);
        queue_random(250);
        wait_idle();

        write_full_height(8'd0);
        idle_mode = IDLE_RECEIVER;
        pick_hot_bins();
        queue_random(250);
        wait_idle();

        write_full_height(8'd255);
        idle_mode = IDLE_BOTH;
        pick_hot_bins();
        queue_random(250);
        wait_idle();

        // Back-pressure: hold the result side off while commands keep
        // coming so the block fills and stalls its input.
        write_full_height(8'($urandom_range(254, 2)));
        idle_mode = IDLE_NONE;
        pick_hot_bins();
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        queue_random(80);
        wait_idle();

        write_full_height(8'($urandom_range(254, 2)));
        pick_hot_bins();
        queue_random(215);
        wait_idle();

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: end the run as failed if it hangs.
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
